// File: rtl/pss_pkg.sv
`default_nettype none

package pss_pkg;

  localparam int unsigned DEF_MAX_LIMIT = 65536;
  localparam int unsigned CFG_W         = 17;
  localparam int unsigned NUM_W         = 16;
  localparam int unsigned FIRST_CAND    = 2;
  localparam int unsigned MIN_LIMIT     = 3;

  localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(65536);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_MARK
  } state_t;

  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic             is_prime;
    logic             last;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/pss_ram.sv
`default_nettype none

module pss_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/pss_core.sv
`default_nettype none

module pss_core #(
  parameter int unsigned MAX_LIMIT = pss_pkg::DEF_MAX_LIMIT,
  parameter int unsigned AW        = $clog2(MAX_LIMIT)
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_restart,
  output logic                 in_ready,
  input  wire  [AW:0]          eff,
  input  wire                  out_free,
  output logic                 res_valid,
  output pss_pkg::result_t     res,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic                 mem_wdata,
  output logic [AW-1:0]        mem_raddr,
  input  wire                  mem_rdata
);

  import pss_pkg::*;

  localparam int unsigned NW = (AW > NUM_W) ? AW : NUM_W;
  localparam int unsigned JW = AW + 2;
  localparam int unsigned SW = 2 * AW;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   nc_r, nc_nxt;
  logic [AW-1:0]   cand_r, cand_nxt;
  logic            prime_r, prime_nxt;
  logic            restart_r, restart_nxt;
  logic [SW-1:0]   sq_r, sq_nxt;
  logic [JW-1:0]   j_r, j_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  result_t         res_r, res_nxt;

  logic [AW-1:0]   top_w;
  logic [AW-1:0]   cand_w;
  logic [NW-1:0]   num_ext;
  logic [JW-1:0]   j_sum;

  assign top_w   = AW'(eff - (AW+1)'(1));
  assign cand_w  = (nc_r > top_w) ? top_w : nc_r;
  assign num_ext = NW'(cand_r);
  assign j_sum   = j_r + JW'(cand_r);
  assign res     = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      nc_r      <= AW'(FIRST_CAND);
      clr_r     <= '0;
      restart_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      nc_r      <= nc_nxt;
      clr_r     <= clr_nxt;
      restart_r <= restart_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r  <= cand_nxt;
    prime_r <= prime_nxt;
    sq_r    <= sq_nxt;
    j_r     <= j_nxt;
    res_r   <= res_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    nc_nxt      = nc_r;
    cand_nxt    = cand_r;
    prime_nxt   = prime_r;
    restart_nxt = restart_r;
    sq_nxt      = sq_r;
    j_nxt       = j_r;
    clr_nxt     = clr_r;
    res_nxt     = res_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = clr_r;
    mem_wdata   = 1'b0;
    mem_raddr   = cand_w;

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(MAX_LIMIT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_restart) begin
            res_nxt     = '0;
            restart_nxt = 1'b1;
            nc_nxt      = AW'(FIRST_CAND);
            state_nxt   = ST_EMIT;
          end else begin
            cand_nxt    = cand_w;
            restart_nxt = 1'b0;
            state_nxt   = ST_READ;
          end
        end
      end
      ST_READ: begin
        prime_nxt       = ~mem_rdata;
        sq_nxt          = SW'(cand_r) * SW'(cand_r);
        nc_nxt          = (cand_r < top_w) ? cand_r + AW'(1) : cand_r;
        res_nxt.number  = num_ext[NUM_W-1:0];
        res_nxt.is_prime = ~mem_rdata;
        res_nxt.last    = (cand_r == top_w);
        state_nxt       = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          res_valid = 1'b1;
          if (restart_r) begin
            clr_nxt   = '0;
            state_nxt = ST_CLEAR;
          end else if (prime_r && (sq_r < SW'(eff))) begin
            j_nxt     = sq_r[JW-1:0];
            state_nxt = ST_MARK;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = j_r[AW-1:0];
        mem_wdata = 1'b1;
        j_nxt     = j_sum;
        if (j_sum >= JW'(eff)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/prime_sieve_stream_unit.sv
`default_nettype none

// Advance word: after acceptance the map is read in ST_READ, then in ST_EMIT
// the result is loaded into the output register once that is free; the next
// word is taken after a prime p with p*p < limit has marked its multiples from
// p*p up, one map write per cycle. Restart word: goes straight to ST_EMIT with a
// zero result; the next word is taken after a map clear of MAX_LIMIT entries.
// Reset: limit = 65536, candidate = 2, map clear of MAX_LIMIT entries before the
// first word is taken.
module prime_sieve_stream_unit #(
  parameter int unsigned MAX_LIMIT = pss_pkg::DEF_MAX_LIMIT
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       cfg_wr_en,
  input  wire  [pss_pkg::CFG_W-1:0] cfg_wr_data,  // limit
  input  wire                       in_tvalid,
  output logic                      in_tready,
  input  wire  [7:0]                in_tdata,     // [0] restart
  output logic                      out_tvalid,
  input  wire                       out_tready,
  output logic [15:0]               out_tdata,    // [15:0] number
  output logic [0:0]                out_tuser,    // [0] is_prime
  output logic                      out_tlast
);

  import pss_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LIMIT);
  localparam int unsigned EW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

  logic [CFG_W-1:0] limit_r;
  logic [EW-1:0]    lim_ext;
  logic [EW-1:0]    lim_sat;
  logic [AW:0]      eff;

  logic             out_valid_r;
  result_t          out_data_r;
  logic             out_free;
  logic             res_valid;
  result_t          res;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic             mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic             mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  assign lim_ext = EW'(limit_r);

  always_comb begin
    lim_sat = lim_ext;
    if (lim_ext > EW'(MAX_LIMIT)) begin
      lim_sat = EW'(MAX_LIMIT);
    end
    if (lim_ext < EW'(MIN_LIMIT)) begin
      lim_sat = EW'(MIN_LIMIT);
    end
  end

  assign eff = lim_sat[AW:0];

  pss_core #(
    .MAX_LIMIT (MAX_LIMIT),
    .AW        (AW)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_restart (in_tdata[0]),
    .in_ready   (in_tready),
    .eff        (eff),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  pss_ram #(
    .WIDTH (1),
    .DEPTH (MAX_LIMIT)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r.number;
  assign out_tuser[0] = out_data_r.is_prime;
  assign out_tlast    = out_data_r.last;

`ifndef SYNTHESIS
  a_no_write_when_ready: assert property (
    @(posedge clk) disable iff (!rst_n) in_tready |-> !mem_we
  ) else $error("map write while accepting input");

  a_zero_not_prime: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata == 16'd0) |-> !out_tuser[0]
  ) else $error("number zero flagged prime");

  a_no_overwrite: assert property (
    @(posedge clk) disable iff (!rst_n) res_valid |-> out_free
  ) else $error("result loaded over pending word");
`endif

endmodule

`default_nettype wire
